/* src/k_way_heap_merge_core_assert.svh */
// assertion macros shared by the heap merge rtl
`ifndef K_WAY_HEAP_MERGE_CORE_ASSERT_SVH
`define K_WAY_HEAP_MERGE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HKM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap merge check failed");

// next-cycle implication, checked outside reset
`define HKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap merge check failed");

`endif

/* src/hkm_pkg.sv */
// ----------------------------------------------------------------------------
// hkm_pkg
// types, codes and the ordering function of the heap merge engine
// ----------------------------------------------------------------------------
package hkm_pkg;

    localparam int RUN_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_BUILD   = 2'd1,
        OP_REPLACE = 2'd2,
        OP_SPENT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_FETCHW,
        S_RDL,
        S_RDR,
        S_CMP,
        S_RES
    } state_t;

    typedef struct packed {
        logic              spent;
        logic [RUN_W-1:0]  run;
        logic signed [31:0] key;
    } entry_t;

    // true when a orders strictly before b; exhausted entries sort last
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic r;
        if (a.spent != b.spent)
        begin
            r = b.spent;
        end
        else if (a.spent)
        begin
            r = 1'b0;
        end
        else
        begin
            r = (a.key < b.key);
        end
        return r;
    endfunction

endpackage

/* src/hkm_heap_ram.sv */
// ----------------------------------------------------------------------------
// hkm_heap_ram
// heap entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module hkm_heap_ram
    import hkm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/k_way_heap_merge_core.sv */
// ----------------------------------------------------------------------------
// k_way_heap_merge_core
// k-way merge engine on a binary min-heap held in a single heap memory
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries op and value; output channel
// out_valid/out_ready carries min_value, min_run, emit_valid, done_res, error.
// every input transfer yields exactly one output transfer.
// load and rejected items go from idle straight to the result state.
// replace and exhaust sift the root down; each heap level takes the steps read
// left child, read right child, compare and write back, over the one read port.
// build runs one sift-down per inner node, each with one extra fetch of the
// node and a final write of it into its resting slot, so loaded_reg/2 sifts,
// rounded down.
// one item is worked on at a time; a new input transfer is taken once the
// engine is idle and the output register is empty or being drained.
// a stalled receiver simply holds the result in the output register.
// reset empties the heap, returns to the loading phase and clears the
// output valid flag; the memory itself needs no clearing.
// ----------------------------------------------------------------------------
module k_way_heap_merge_core
    import hkm_pkg::*;
#(
    parameter int MAX_RUNS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] min_value,
    output logic [3:0]         min_run,
    output logic               emit_valid,
    output logic               done_res,
    output logic               error
);

    localparam int IW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int XW = IW + 2;

    state_t state_reg, state_next;
    logic [CW-1:0] loaded_reg, loaded_next;
    logic [CW-1:0] spent_reg, spent_next;
    logic merging_reg, merging_next;
    logic build_reg, build_next;
    logic err_reg, err_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] bp_reg, bp_next;
    entry_t cur_reg, cur_next;
    entry_t best_reg, best_next;
    logic [IW-1:0] bidx_reg, bidx_next;
    logic bchild_reg, bchild_next;
    entry_t root_reg, root_next;

    logic out_valid_reg, out_valid_next;
    logic signed [31:0] min_value_reg, min_value_next;
    logic [3:0] min_run_reg, min_run_next;
    logic emit_reg, emit_next;
    logic done_reg, done_next;
    logic error_reg, error_next;

    logic we;
    logic [IW-1:0] waddr, raddr;
    entry_t wdata, rdata;

    logic in_fire;
    logic [XW-1:0] lc_w, rc_w, n_w;
    logic lc_ok, rc_ok, left_wins, rc_wins, is_done, load_bad, take_child;
    logic [CW-2:0] half;
    op_t op_in;

    hkm_heap_ram #(
        .DEPTH (MAX_RUNS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign op_in     = op_t'(op);
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign lc_w      = {1'b0, pos_reg, 1'b1};
    assign rc_w      = lc_w + XW'(1);
    assign n_w       = XW'(loaded_reg);
    assign lc_ok     = lc_w < n_w;
    assign rc_ok     = rc_w < n_w;
    assign left_wins = goes_before(rdata, cur_reg);
    assign rc_wins   = rc_ok && goes_before(rdata, best_reg);
    assign take_child = rc_wins || bchild_reg;
    assign is_done   = merging_reg && (spent_reg == loaded_reg);
    assign load_bad  = merging_reg || (loaded_reg == CW'(MAX_RUNS));
    assign half      = loaded_reg[CW-1:1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_in)
                        OP_LOAD:  state_next = S_RES;
                        OP_BUILD:
                        begin
                            if (merging_reg || half == '0)
                                state_next = S_RES;
                            else
                                state_next = S_FETCH;
                        end
                        default:
                        begin
                            if (!merging_reg || is_done)
                                state_next = S_RES;
                            else
                                state_next = S_RDL;
                        end
                    endcase
                end
            end
            S_FETCH:  state_next = S_FETCHW;
            S_FETCHW: state_next = S_RDL;
            S_RDL:
            begin
                if (lc_ok)
                    state_next = S_RDR;
                else if (build_reg && bp_reg != '0)
                    state_next = S_FETCH;
                else
                    state_next = S_RES;
            end
            S_RDR:    state_next = S_CMP;
            S_CMP:
            begin
                if (take_child)
                    state_next = S_RDL;
                else if (build_reg && bp_reg != '0)
                    state_next = S_FETCH;
                else
                    state_next = S_RES;
            end
            S_RES:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        loaded_next    = loaded_reg;
        spent_next     = spent_reg;
        merging_next   = merging_reg;
        build_next     = build_reg;
        err_next       = err_reg;
        pos_next       = pos_reg;
        bp_next        = bp_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        bidx_next      = bidx_reg;
        bchild_next    = bchild_reg;
        out_valid_next = out_valid_reg && !out_ready;
        min_value_next = min_value_reg;
        min_run_next   = min_run_reg;
        emit_next      = emit_reg;
        done_next      = done_reg;
        error_next     = error_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = cur_reg;
        raddr          = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    err_next   = 1'b0;
                    build_next = 1'b0;
                    case (op_in)
                        OP_LOAD:
                        begin
                            if (load_bad)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                we          = 1'b1;
                                waddr       = IW'(loaded_reg);
                                wdata.key   = value;
                                wdata.run   = RUN_W'(loaded_reg);
                                wdata.spent = 1'b0;
                                loaded_next = loaded_reg + CW'(1);
                            end
                        end
                        OP_BUILD:
                        begin
                            if (merging_reg)
                                err_next = 1'b1;
                            else if (half == '0)
                                merging_next = 1'b1;
                            else
                            begin
                                build_next = 1'b1;
                                bp_next    = IW'(half - 1'b1);
                                pos_next   = IW'(half - 1'b1);
                            end
                        end
                        default:
                        begin
                            if (!merging_reg || is_done)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                pos_next = '0;
                                cur_next = root_reg;
                                if (op_in == OP_REPLACE)
                                begin
                                    cur_next.key = value;
                                end
                                else
                                begin
                                    cur_next.spent = 1'b1;
                                    spent_next     = spent_reg + CW'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_FETCHW:
            begin
                cur_next = rdata;
            end
            S_RDL:
            begin
                if (lc_ok)
                begin
                    raddr = lc_w[IW-1:0];
                end
                else
                begin
                    we = 1'b1;
                    if (build_reg)
                    begin
                        if (bp_reg != '0)
                        begin
                            bp_next  = bp_reg - 1'b1;
                            pos_next = bp_reg - 1'b1;
                        end
                        else
                        begin
                            merging_next = 1'b1;
                        end
                    end
                end
            end
            S_RDR:
            begin
                raddr = rc_w[IW-1:0];
                bidx_next = lc_w[IW-1:0];
                if (left_wins)
                begin
                    best_next   = rdata;
                    bchild_next = 1'b1;
                end
                else
                begin
                    best_next   = cur_reg;
                    bchild_next = 1'b0;
                end
            end
            S_CMP:
            begin
                we = 1'b1;
                if (take_child)
                begin
                    // promote the winning child, keep sifting from its slot
                    wdata    = rc_wins ? rdata : best_reg;
                    pos_next = rc_wins ? rc_w[IW-1:0] : bidx_reg;
                end
                else if (build_reg)
                begin
                    if (bp_reg != '0)
                    begin
                        bp_next  = bp_reg - 1'b1;
                        pos_next = bp_reg - 1'b1;
                    end
                    else
                    begin
                        merging_next = 1'b1;
                    end
                end
            end
            S_RES:
            begin
                out_valid_next = 1'b1;
                emit_next      = merging_reg && (loaded_reg != '0) && !root_reg.spent;
                done_next      = is_done;
                error_next     = err_reg;
                min_value_next = emit_next ? root_reg.key : '0;
                min_run_next   = emit_next ? root_reg.run[3:0] : '0;
            end
            default:
            begin
            end
        endcase

        root_next = root_reg;
        if (we && waddr == '0)
        begin
            root_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            spent_reg     <= '0;
            merging_reg   <= 1'b0;
            build_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            spent_reg     <= spent_next;
            merging_reg   <= merging_next;
            build_reg     <= build_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        bp_reg        <= bp_next;
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        bidx_reg      <= bidx_next;
        bchild_reg    <= bchild_next;
        root_reg      <= root_next;
        min_value_reg <= min_value_next;
        min_run_reg   <= min_run_next;
        emit_reg      <= emit_next;
        done_reg      <= done_next;
        error_reg     <= error_next;
    end

    assign out_valid  = out_valid_reg;
    assign min_value  = min_value_reg;
    assign min_run    = min_run_reg;
    assign emit_valid = emit_reg;
    assign done_res   = done_reg;
    assign error      = error_reg;

`include "k_way_heap_merge_core_assert.svh"

    `HKM_ASSERT_NOW(a_busy_blocks_input, state_reg != S_IDLE, !in_ready)
    `HKM_ASSERT_NOW(a_spent_bounded, 1'b1, spent_reg <= loaded_reg)
    `HKM_ASSERT_NOW(a_emit_xor_done, out_valid_reg, !(emit_reg && done_reg))
    `HKM_ASSERT_NEXT(a_res_presents, state_reg == S_RES, out_valid_reg)

endmodule

/* bench/k_way_heap_merge_core_tb.sv */
// ----------------------------------------------------------------------------
// k_way_heap_merge_core_tb
// self-checking bench for the binary min-heap k-way merge engine
// ----------------------------------------------------------------------------
// a short table of directed items covers phase errors, a full load of 16
// runs with extreme keys, overload and build. A long random merge of
// replace items and sparse exhausts follows, until every run is exhausted.
// each result is compared with a heap model kept in the bench. Both sides
// stall at random. The receiver also holds off for a long stretch, and the
// sender pauses once until every result has drained.
// ----------------------------------------------------------------------------
module k_way_heap_merge_core_tb
    import hkm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUNS       = 16;
    localparam int RAND_ITEMS = 1680;
    localparam int STALL_MAX  = 3000;
    localparam int LONG_HOLD  = 200;

    typedef struct {
        logic signed [31:0] key;
        logic [3:0]         run;
        logic               emit;
        logic               fin;
        logic               err;
    } status_t;

    typedef struct {
        op_t                op;
        logic signed [31:0] val;
        bit                 typed;
        status_t            want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] min_value;
    logic [3:0]         min_run;
    logic               emit_valid;
    logic               done_res;
    logic               error;

    // heap image kept by the bench
    logic signed [31:0] hk [RUNS];
    logic [3:0]         hr [RUNS];
    logic               hs [RUNS];
    int                 loaded_n;
    int                 spent_n;
    logic               merging;

    status_t            pending_q [$];
    int                 errors;
    bit                 quiet;
    bit                 hold_long;
    row_t               dir_rows [25];

    k_way_heap_merge_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .min_value  (min_value),
        .min_run    (min_run),
        .emit_valid (emit_valid),
        .done_res   (done_res),
        .error      (error)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic orders_first(int a, int b);
        if (hs[a] != hs[b])
        begin
            return hs[b];
        end
        if (hs[a])
        begin
            return 1'b0;
        end
        return hk[a] < hk[b];
    endfunction

    function automatic void sink(int start);
        int                 p;
        int                 best;
        logic signed [31:0] tk;
        logic [3:0]         tr;
        logic               ts;
        p = start;
        while (p < loaded_n)
        begin
            best = p;
            if (2 * p + 1 < loaded_n && orders_first(2 * p + 1, p))
            begin
                best = 2 * p + 1;
            end
            if (2 * p + 2 < loaded_n && orders_first(2 * p + 2, best))
            begin
                best = 2 * p + 2;
            end
            if (best == p)
            begin
                break;
            end
            tk = hk[p]; tr = hr[p]; ts = hs[p];
            hk[p] = hk[best]; hr[p] = hr[best]; hs[p] = hs[best];
            hk[best] = tk; hr[best] = tr; hs[best] = ts;
            p = best;
        end
    endfunction

    function automatic logic merge_finished();
        return merging && spent_n == loaded_n;
    endfunction

    function automatic status_t heap_apply(op_t o, logic signed [31:0] v);
        status_t s;
        logic    bad;
        int      p;
        bad = 1'b0;
        case (o)
            OP_LOAD:
            begin
                if (merging || loaded_n >= RUNS)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    hk[loaded_n] = v;
                    hr[loaded_n] = loaded_n[3:0];
                    hs[loaded_n] = 1'b0;
                    loaded_n++;
                end
            end
            OP_BUILD:
            begin
                if (merging)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (p = loaded_n / 2 - 1; p >= 0; p--)
                    begin
                        sink(p);
                    end
                    merging = 1'b1;
                end
            end
            default:
            begin
                if (!merging || merge_finished())
                begin
                    bad = 1'b1;
                end
                else if (o == OP_REPLACE)
                begin
                    hk[0] = v;
                    sink(0);
                end
                else
                begin
                    hs[0] = 1'b1;
                    spent_n++;
                    sink(0);
                end
            end
        endcase
        s.emit = merging && loaded_n > 0 && !hs[0];
        s.key  = s.emit ? hk[0] : '0;
        s.run  = s.emit ? hr[0] : '0;
        s.fin  = merge_finished();
        s.err  = bad;
        return s;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // offer one item, wait for its transfer, then maybe idle
    task automatic send(op_t o, logic signed [31:0] v, bit typed, status_t want);
        status_t s;
        int      gap;
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        s = heap_apply(o, v);
        pending_q.insert(pending_q.size(), typed ? want : s);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return '0;
            3:       return -32'sd1;
            4:       return $signed($urandom_range(0, 40)) - 20;
            default: return $signed($urandom);
        endcase
    endfunction

    // result checking
    always @(posedge clk)
    begin
        status_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                report("unexpected result", min_value, 0);
            end
            else
            begin
                w = pending_q.pop_front();
                if (min_value !== w.key)   report("min_value", min_value, w.key);
                if (min_run !== w.run)     report("min_run", min_run, w.run);
                if (emit_valid !== w.emit) report("emit_valid", emit_valid, w.emit);
                if (done_res !== w.fin)    report("done_res", done_res, w.fin);
                if (error !== w.err)       report("error", error, w.err);
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        int idle;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle = 0;
        end
        else
        begin
            idle++;
            if (idle >= STALL_MAX)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        status_t z;
        status_t e;
        op_t     o;
        int      i;
        int      r;
        z = '{key: '0, run: '0, emit: 1'b0, fin: 1'b0, err: 1'b0};
        e = z;
        e.err = 1'b1;
        dir_rows[0]  = '{OP_REPLACE, 32'sd5,        1'b1, e};
        dir_rows[1]  = '{OP_SPENT,   32'sd0,        1'b1, e};
        dir_rows[2]  = '{OP_LOAD,    32'sh80000000, 1'b1, z};
        dir_rows[3]  = '{OP_LOAD,    32'sh7fffffff, 1'b1, z};
        dir_rows[4]  = '{OP_LOAD,    32'sd0,        1'b1, z};
        dir_rows[5]  = '{OP_LOAD,    -32'sd1,       1'b1, z};
        dir_rows[6]  = '{OP_LOAD,    32'sd7,        1'b1, z};
        dir_rows[7]  = '{OP_LOAD,    32'sd7,        1'b1, z};
        dir_rows[8]  = '{OP_LOAD,    -32'sd100,     1'b1, z};
        dir_rows[9]  = '{OP_LOAD,    32'sd100,      1'b1, z};
        dir_rows[10] = '{OP_LOAD,    32'sh55555555, 1'b1, z};
        dir_rows[11] = '{OP_LOAD,    32'shaaaaaaaa, 1'b1, z};
        dir_rows[12] = '{OP_LOAD,    32'sd1,        1'b1, z};
        dir_rows[13] = '{OP_LOAD,    -32'sd2,       1'b1, z};
        dir_rows[14] = '{OP_LOAD,    32'sd42,       1'b1, z};
        dir_rows[15] = '{OP_LOAD,    32'sh7fffffff, 1'b1, z};
        dir_rows[16] = '{OP_LOAD,    32'sh80000000, 1'b1, z};
        dir_rows[17] = '{OP_LOAD,    32'sd3,        1'b1, z};
        // seventeenth load is over capacity
        dir_rows[18] = '{OP_LOAD,    32'sd9,        1'b1, e};
        dir_rows[19] = '{OP_BUILD,   32'sd0,        1'b0, z};
        dir_rows[20] = '{OP_BUILD,   32'sd0,        1'b0, z};
        dir_rows[21] = '{OP_LOAD,    32'sd11,       1'b0, z};
        dir_rows[22] = '{OP_REPLACE, 32'sh7fffffff, 1'b0, z};
        dir_rows[23] = '{OP_REPLACE, 32'sh80000000, 1'b0, z};
        dir_rows[24] = '{OP_SPENT,   32'sd0,        1'b0, z};

        errors    = 0;
        quiet     = 1'b0;
        hold_long = 1'b0;
        loaded_n  = 0;
        spent_n   = 0;
        merging   = 1'b0;
        for (i = 0; i < RUNS; i++)
        begin
            hk[i] = '0;
            hr[i] = '0;
            hs[i] = 1'b0;
        end
        in_valid = 1'b0;
        op       = OP_LOAD;
        value    = '0;
        rst_n    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k])
        begin
            send(dir_rows[k].op, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].want);
        end

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 500)
            begin
                hold_long = 1'b1;
            end
            if (i == 1100)
            begin
                // let everything drain before going on
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_q.size() != 0) @(negedge clk);
            end
            if (i == RAND_ITEMS - 150)
            begin
                quiet = 1'b1;
            end
            r = $urandom_range(0, 999);
            if (merge_finished())
            begin
                o = op_t'($urandom_range(0, 3));
            end
            else if (i >= RAND_ITEMS - 80)
            begin
                o = OP_SPENT;
            end
            else if (r < 25)
            begin
                o = OP_LOAD;
            end
            else if (r < 45)
            begin
                o = OP_BUILD;
            end
            else if (r < 51)
            begin
                o = OP_SPENT;
            end
            else
            begin
                o = OP_REPLACE;
            end
            send(o, pick_value(), 1'b0, z);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
